@@ rtl/core/celb_pkg.sv @@
// Shared codes, key values and result type for the console line edit buffer.
package celb_pkg;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_CHAR  = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;

    localparam logic [7:0] KEY_NUL    = 8'h00;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_H = 8'h08;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_CTRL_P = 8'h10;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_DEL    = 8'h7F;

    localparam logic [7:0] ERASE_MAX  = 8'hFF;

    typedef struct packed {
        logic [1:0] echo_kind;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic       read_valid;
    } celb_result_t;

endpackage

@@ rtl/core/celb_if.sv @@
// Valid/ready channel interfaces for the console line edit buffer.
interface celb_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_char;

    modport source (output valid, output op, output rx_char, input ready);
    modport sink   (input valid, input op, input rx_char, output ready);
endinterface

interface celb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] echo_kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       read_valid;
    logic [7:0] read_char;

    modport source (output valid, output echo_kind, output echo_char, output erase_count,
                    output read_valid, output read_char, input ready);
    modport sink   (input valid, input echo_kind, input echo_char, input erase_count,
                    input read_valid, input read_char, output ready);
endinterface

@@ rtl/core/celb_line_mem.sv @@
// Line store: one write port, one registered read port.
module celb_line_mem #(
    parameter int BUF_DEPTH = 128,
    parameter int AW        = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/celb_edit_ctrl.sv @@
// Pointer state, key decode and line store access control.
module celb_edit_ctrl import celb_pkg::*; #(
    parameter int BUF_DEPTH = 128,
    parameter int AW        = 7,
    parameter int PW        = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic          op,
    input  logic [7:0]    rx_char,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    output celb_result_t  result
);

    localparam logic [PW:0]   PMOD  = (PW+1)'(2 * BUF_DEPTH);
    localparam logic [PW-1:0] DEPTH = PW'(BUF_DEPTH);
    localparam logic [PW-1:0] PLAST = PW'(2 * BUF_DEPTH - 1);
    localparam int            CW    = (PW > 8) ? PW : 8;

    logic [PW-1:0] read_ptr_reg, read_ptr_next;
    logic [PW-1:0] commit_ptr_reg, commit_ptr_next;
    logic [PW-1:0] edit_ptr_reg, edit_ptr_next;
    logic [PW-1:0] dist_ec, dist_er, dist_cr;
    logic [CW-1:0] dist_ec_ext;
    logic [7:0]    ch;

    function automatic logic [PW-1:0] ptr_dist(input logic [PW-1:0] hi,
                                               input logic [PW-1:0] lo);
        logic [PW:0] d;
        d = {1'b0, hi} - {1'b0, lo};
        if (d[PW])
        begin
            d = d + PMOD;
        end
        return d[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PLAST) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PLAST : p - PW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= DEPTH) ? p - DEPTH : p;
        return s[AW-1:0];
    endfunction

    assign dist_ec     = ptr_dist(edit_ptr_reg, commit_ptr_reg);
    assign dist_er     = ptr_dist(edit_ptr_reg, read_ptr_reg);
    assign dist_cr     = ptr_dist(commit_ptr_reg, read_ptr_reg);
    assign dist_ec_ext = CW'(dist_ec);
    assign mem_raddr   = ptr_slot(read_ptr_reg);
    assign mem_waddr   = ptr_slot(edit_ptr_reg);

    always_comb
    begin
        read_ptr_next   = read_ptr_reg;
        commit_ptr_next = commit_ptr_reg;
        edit_ptr_next   = edit_ptr_reg;
        result          = '0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        ch              = (rx_char == KEY_CR || rx_char == KEY_CTRL_D) ? KEY_LF : rx_char;
        mem_wdata       = ch;
        if (fire)
        begin
            if (op == OP_READ)
            begin
                if (read_ptr_reg != commit_ptr_reg)
                begin
                    mem_re            = 1'b1;
                    result.read_valid = 1'b1;
                    read_ptr_next     = ptr_inc(read_ptr_reg);
                end
            end
            else if (rx_char == KEY_NUL || rx_char == KEY_CTRL_P)
            begin
                result = '0;
            end
            else if (rx_char == KEY_CTRL_U)
            begin
                if (dist_ec != '0)
                begin
                    edit_ptr_next      = commit_ptr_reg;
                    result.echo_kind   = ECHO_ERASE;
                    result.erase_count = (dist_ec_ext > CW'(ERASE_MAX)) ? ERASE_MAX
                                                                        : dist_ec_ext[7:0];
                end
            end
            else if (rx_char == KEY_CTRL_H || rx_char == KEY_DEL)
            begin
                if (edit_ptr_reg != commit_ptr_reg)
                begin
                    edit_ptr_next      = ptr_dec(edit_ptr_reg);
                    result.echo_kind   = ECHO_ERASE;
                    result.erase_count = 8'd1;
                end
            end
            else if (dist_er < DEPTH)
            begin
                mem_we           = 1'b1;
                result.echo_kind = ECHO_CHAR;
                result.echo_char = ch;
                edit_ptr_next    = ptr_inc(edit_ptr_reg);
                if (ch == KEY_LF || dist_er == DEPTH - PW'(1))
                begin
                    commit_ptr_next = ptr_inc(edit_ptr_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_ptr_reg   <= '0;
            commit_ptr_reg <= '0;
            edit_ptr_reg   <= '0;
        end
        else
        begin
            read_ptr_reg   <= read_ptr_next;
            commit_ptr_reg <= commit_ptr_next;
            edit_ptr_reg   <= edit_ptr_next;
        end
    end

    // ring never holds more than its depth
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dist_er <= DEPTH)
        else $error("ring occupancy exceeds depth");

    // committed region lies inside the filled region
    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        dist_cr <= dist_er)
        else $error("commit pointer beyond edit pointer");

    // stored newline commits the whole line
    a_lf_commits: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && ch == KEY_LF) |=> (commit_ptr_reg == edit_ptr_reg))
        else $error("newline did not commit");

    // erase echo always reports at least one character
    a_erase_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.echo_kind == ECHO_ERASE) |-> (result.erase_count != 8'd0))
        else $error("erase echo with zero count");

endmodule

@@ rtl/core/console_line_edit_buffer.sv @@
// Top level of the console line edit buffer: channel handshake and result register.
// Each input transfer is either a received byte (op 0) or a consumer read (op 1)
// and yields exactly one result transfer. Unless the output stalls, the block takes
// one item per cycle: the pointer update and the line store access finish in the
// accept cycle, and the result, including the byte read from the store's registered
// port, appears in the output register in the next cycle. A new item is taken
// whenever the output register is empty or drains in the same cycle. No clearing
// pass is needed after reset; the store is only read at committed entries.
module console_line_edit_buffer import celb_pkg::*; #(
    parameter int BUF_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    celb_in_if.sink     in_ch,
    celb_out_if.source  out_ch
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int PW = $clog2(2 * BUF_DEPTH);

    logic          fire;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    celb_result_t  res_next;
    celb_result_t  res_reg;
    logic          out_valid_reg, out_valid_next;

    assign in_ch.ready    = !out_valid_reg || out_ch.ready;
    assign fire           = in_ch.valid && in_ch.ready;
    assign out_valid_next = fire || (out_valid_reg && !out_ch.ready);

    celb_edit_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW),
        .PW        (PW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .op        (in_ch.op),
        .rx_char   (in_ch.rx_char),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .result    (res_next)
    );

    celb_line_mem #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.echo_kind   = res_reg.echo_kind;
    assign out_ch.echo_char   = res_reg.echo_char;
    assign out_ch.erase_count = res_reg.erase_count;
    assign out_ch.read_valid  = res_reg.read_valid;
    assign out_ch.read_char   = res_reg.read_valid ? mem_rdata : 8'd0;

endmodule
